// ===== hw/rtl/dbrc_pkg.sv =====
`default_nettype none

package dbrc_pkg;

    localparam int WEIGHT_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd10;
    localparam logic [CFG_W-1:0] HOLDOFF_RESET   = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_SAMPLE     = 2'd0,
        FUNC_LINK       = 2'd1,
        FUNC_OBOX_RESET = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_ENABLED   = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_HOLDOFF   = 2'd2
    } cfg_index_t;

    // one result word
    typedef struct packed {
        logic                known;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } word_t;

    // front to queue, second word only together with the first
    typedef struct packed {
        logic  push0;
        logic  push1;
        word_t w0;
        word_t w1;
    } push_t;

    typedef struct packed {
        logic room2;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dbrc_front.sv =====
`default_nettype none

module dbrc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [dbrc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_accept,
    input  wire logic [1:0]                      func,
    input  wire logic                            sample_known,
    input  wire logic [dbrc_pkg::WEIGHT_W-1:0]   weight_dg,
    input  wire logic                            force_req,
    input  wire logic [dbrc_pkg::TIME_W-1:0]     now_ms,
    input  wire logic                            outbox_accepts,
    output dbrc_pkg::push_t                      push
);
    import dbrc_pkg::*;

    logic                enabled_reg;
    logic [CFG_W-1:0]    threshold_reg;
    logic [CFG_W-1:0]    holdoff_reg;

    logic                lk_reg, lk_next;
    logic [WEIGHT_W-1:0] lw_reg, lw_next;
    logic                have_reg, have_next;
    logic                rv_reg, rv_next;
    logic                rk_reg, rk_next;
    logic [WEIGHT_W-1:0] rw_reg, rw_next;
    logic [TIME_W-1:0]   rt_reg, rt_next;
    logic                hp_reg, hp_next;
    logic                hk_reg, hk_next;
    logic [WEIGHT_W-1:0] hw_reg, hw_next;

    logic [TIME_W-1:0]   elapsed;
    logic                win0, win1;
    logic                flush;
    logic                rv1, rk1;
    logic [WEIGHT_W:0]   diff_r, diff_h, mag_r, mag_h;
    logic                far_r, far_h, far;
    logic                worth, hold, issue_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            threshold_reg <= THRESHOLD_RESET;
            holdoff_reg   <= HOLDOFF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLED:   enabled_reg   <= cfg_data[0];
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_HOLDOFF:   holdoff_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold-off window and deadband, the second test sees the state after a flush
    always_comb
    begin
        elapsed   = now_ms - rt_reg;
        win0      = elapsed < {{(TIME_W-CFG_W){1'b0}}, holdoff_reg};
        diff_r    = {weight_dg[WEIGHT_W-1], weight_dg} - {rw_reg[WEIGHT_W-1], rw_reg};
        diff_h    = {weight_dg[WEIGHT_W-1], weight_dg} - {hw_reg[WEIGHT_W-1], hw_reg};
        mag_r     = diff_r[WEIGHT_W] ? (~diff_r + 1'b1) : diff_r;
        mag_h     = diff_h[WEIGHT_W] ? (~diff_h + 1'b1) : diff_h;
        far_r     = mag_r >= {1'b0, threshold_reg};
        far_h     = mag_h >= {1'b0, threshold_reg};
        flush     = hp_reg && (force_req || !win0) && outbox_accepts;
        rv1       = flush ? 1'b1 : rv_reg;
        rk1       = flush ? hk_reg : rk_reg;
        far       = flush ? far_h : far_r;
        win1      = flush ? (holdoff_reg != '0) : win0;
        worth     = force_req || !rv1 || (sample_known != rk1)
                    || (sample_known && far);
        hold      = worth && !force_req && rv1 && (sample_known == rk1) && win1;
        issue_new = worth && !hold && outbox_accepts;
    end

    always_comb
    begin
        lk_next   = lk_reg;
        lw_next   = lw_reg;
        have_next = have_reg;
        rv_next   = rv_reg;
        rk_next   = rk_reg;
        rw_next   = rw_reg;
        rt_next   = rt_reg;
        hp_next   = hp_reg;
        hk_next   = hk_reg;
        hw_next   = hw_reg;
        push      = '0;
        if (in_accept)
        begin
            unique case (func_t'(func))
                FUNC_SAMPLE:
                begin
                    lk_next   = sample_known;
                    lw_next   = weight_dg;
                    have_next = 1'b1;
                    if (enabled_reg)
                    begin
                        if (flush)
                        begin
                            rv_next    = 1'b1;
                            rk_next    = hk_reg;
                            rw_next    = hw_reg;
                            rt_next    = now_ms;
                            hp_next    = 1'b0;
                            push.push0 = 1'b1;
                            push.w0    = '{known: hk_reg, weight: hw_reg, last: !issue_new};
                        end
                        if (hold)
                        begin
                            hp_next = 1'b1;
                            hk_next = sample_known;
                            hw_next = weight_dg;
                        end
                        else if (issue_new)
                        begin
                            rv_next = 1'b1;
                            rk_next = sample_known;
                            rw_next = weight_dg;
                            rt_next = now_ms;
                            hp_next = 1'b0;
                            if (flush)
                            begin
                                push.push1 = 1'b1;
                                push.w1    = '{known: sample_known, weight: weight_dg,
                                               last: 1'b1};
                            end
                            else
                            begin
                                push.push0 = 1'b1;
                                push.w0    = '{known: sample_known, weight: weight_dg,
                                               last: 1'b1};
                            end
                        end
                    end
                end
                FUNC_LINK:
                begin
                    if (have_reg && enabled_reg)
                    begin
                        rv_next = 1'b0;
                        hp_next = 1'b0;
                        if (outbox_accepts)
                        begin
                            rv_next    = 1'b1;
                            rk_next    = lk_reg;
                            rw_next    = lw_reg;
                            rt_next    = now_ms;
                            push.push0 = 1'b1;
                            push.w0    = '{known: lk_reg, weight: lw_reg, last: 1'b1};
                        end
                    end
                end
                FUNC_OBOX_RESET:
                begin
                    rv_next = 1'b0;
                    hp_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_reg   <= 1'b0;
            lw_reg   <= '0;
            have_reg <= 1'b0;
            rv_reg   <= 1'b0;
            rk_reg   <= 1'b0;
            rw_reg   <= '0;
            rt_reg   <= '0;
            hp_reg   <= 1'b0;
            hk_reg   <= 1'b0;
            hw_reg   <= '0;
        end
        else
        begin
            lk_reg   <= lk_next;
            lw_reg   <= lw_next;
            have_reg <= have_next;
            rv_reg   <= rv_next;
            rk_reg   <= rk_next;
            rw_reg   <= rw_next;
            rt_reg   <= rt_next;
            hp_reg   <= hp_next;
            hk_reg   <= hk_next;
            hw_reg   <= hw_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dbrc_queue.sv =====
`default_nettype none

module dbrc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dbrc_pkg::push_t         push,
    input  wire logic                    pop,
    output dbrc_pkg::word_t              head,
    output dbrc_pkg::queue_status_t      status
);
    import dbrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [PTR_W-1:0]  wr_plus1;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_plus1 = ptr_inc(wr_reg);
        wr_next  = wr_reg;
        if (push.push1)
            wr_next = ptr_inc(wr_plus1);
        else if (push.push0)
            wr_next = wr_plus1;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
            mem[wr_reg] <= push.w0;
        if (push.push1)
            mem[wr_plus1] <= push.w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head   = mem[rd_reg];
    assign status = '{room2: (cnt_reg <= CNT_W'(DEPTH - 2)), empty: (cnt_reg == '0)};

endmodule

`default_nettype wire

// ===== hw/rtl/dbrc_back.sv =====
`default_nettype none

module dbrc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dbrc_pkg::word_t                 head,
    input  wire logic                            empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 report_known,
    output logic signed [dbrc_pkg::WEIGHT_W-1:0] report_weight,
    output logic                                 last
);
    import dbrc_pkg::*;

    logic                valid_reg;
    logic                known_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                last_reg;

    assign pop = !empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // unknown reports carry an empty payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            known_reg  <= head.known;
            weight_reg <= head.known ? head.weight : '0;
            last_reg   <= head.last;
        end
    end

    assign out_valid     = valid_reg;
    assign report_known  = known_reg;
    assign report_weight = $signed(weight_reg);
    assign last          = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/deadband_report_coalescer.sv =====
// Weight report coalescer: decides per event (sample, link connected, outbox reset)
// whether to emit zero, one or two report words, using a deadband on the weight, a
// known/unknown status check and a hold-off window that coalesces same-status reports
// into one pending report. Events are classified and the state updated at acceptance,
// so a new event can be taken every cycle while the word queue has room for two words
// (in_stall is high otherwise). Report words leave the output register at one per
// cycle while out_stall is low; the first word of an event passes through the word
// queue and then the output register before it is shown. The word that closes an
// event has last set. Configuration writes are always taken (cfg_ready high)
// and must be made while no event is in flight.
`default_nettype none

module deadband_report_coalescer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [dbrc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      func,
    input  wire logic                            sample_known,
    input  wire logic signed [dbrc_pkg::WEIGHT_W-1:0] weight_dg,
    input  wire logic                            force_req,
    input  wire logic [dbrc_pkg::TIME_W-1:0]     now_ms,
    input  wire logic                            outbox_accepts,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 report_known,
    output logic signed [dbrc_pkg::WEIGHT_W-1:0] report_weight,
    output logic                                 last
);
    import dbrc_pkg::*;

    push_t         push;
    word_t         head;
    queue_status_t q_status;
    logic          pop;
    logic          in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = !q_status.room2;
    assign in_accept = in_valid && !in_stall;

    dbrc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_accept      (in_accept),
        .func           (func),
        .sample_known   (sample_known),
        .weight_dg      (weight_dg),
        .force_req      (force_req),
        .now_ms         (now_ms),
        .outbox_accepts (outbox_accepts),
        .push           (push)
    );

    dbrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    dbrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_status.empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .report_known  (report_known),
        .report_weight (report_weight),
        .last          (last)
    );

    // the second word of an event is queued with the first, so it follows at once
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("second report word of an event did not follow");

    a_valid_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_status.empty))
        else $error("report word shown without a queued word");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> in_accept)
        else $error("word pushed without an accepted event");

endmodule

`default_nettype wire

// ===== tb/dbrc_report_monitor.sv =====
`timescale 1ns / 100ps

module dbrc_report_monitor (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [dbrc_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [1:0]                        func,
    input  wire logic                              sample_known,
    input  wire logic signed [dbrc_pkg::WEIGHT_W-1:0] weight_dg,
    input  wire logic                              force_req,
    input  wire logic [dbrc_pkg::TIME_W-1:0]       now_ms,
    input  wire logic                              outbox_accepts,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic                              report_known,
    input  wire logic signed [dbrc_pkg::WEIGHT_W-1:0] report_weight,
    input  wire logic                              last,
    output int                                     mismatches,
    output int                                     words_due
);

    import dbrc_pkg::*;

    logic                en;
    logic [CFG_W-1:0]    thr;
    logic [CFG_W-1:0]    hold;

    logic                lat_known;
    logic [WEIGHT_W-1:0] lat_weight;
    logic                seen_sample;
    logic                rep_valid;
    logic                rep_known;
    logic [WEIGHT_W-1:0] rep_weight;
    logic [TIME_W-1:0]   rep_time;
    logic                held;
    logic                held_known;
    logic [WEIGHT_W-1:0] held_weight;

    word_t               due_reports[$];
    word_t               ev_words[2];
    int                  ev_n;
    logic [TIME_W-1:0]   ev_now;
    logic                ev_accepts;
    int                  errs;

    function automatic logic in_holdoff();
        logic [TIME_W-1:0] elapsed;
        elapsed = ev_now - rep_time;
        return elapsed < {16'd0, hold};
    endfunction

    function automatic logic exceeds_deadband(input logic k, input logic [WEIGHT_W-1:0] w,
                                              input logic frc);
        int d;
        if (frc || !rep_valid || k != rep_known)
            return 1'b1;
        if (!k)
            return 1'b0;
        d = int'($signed(w)) - int'($signed(rep_weight));
        if (d < 0)
            d = -d;
        return d >= int'(thr);
    endfunction

    task automatic emit(input logic k, input logic [WEIGHT_W-1:0] w);
        if (!ev_accepts || ev_n >= 2)
            return;
        ev_words[ev_n].known  = k;
        ev_words[ev_n].weight = k ? w : '0;
        ev_words[ev_n].last   = 1'b0;
        ev_n++;
        rep_valid  = 1'b1;
        rep_known  = k;
        rep_weight = w;
        rep_time   = ev_now;
        held       = 1'b0;
    endtask

    task automatic submit(input logic k, input logic [WEIGHT_W-1:0] w, input logic frc);
        if (!frc && rep_valid && k == rep_known && in_holdoff()) begin
            held        = 1'b1;
            held_known  = k;
            held_weight = w;
        end
        else
        begin
            emit(k, w);
        end
    endtask

    task automatic coalesce_event(input logic [1:0] f, input logic k,
                                  input logic [WEIGHT_W-1:0] w, input logic frc,
                                  input logic [TIME_W-1:0] t, input logic acc);
        word_t wd;
        ev_n       = 0;
        ev_now     = t;
        ev_accepts = acc;
        case (f)
            FUNC_SAMPLE:
            begin
                lat_known   = k;
                lat_weight  = w;
                seen_sample = 1'b1;
                if (en) begin
                    if (held && (frc || !in_holdoff()))
                        emit(held_known, held_weight);
                    if (exceeds_deadband(k, w, frc))
                        submit(k, w, frc);
                end
            end
            FUNC_LINK:
            begin
                if (seen_sample && en) begin
                    rep_valid = 1'b0;
                    held      = 1'b0;
                    submit(lat_known, lat_weight, 1'b1);
                end
            end
            FUNC_OBOX_RESET:
            begin
                rep_valid = 1'b0;
                held      = 1'b0;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < ev_n; i++) begin
            wd      = ev_words[i];
            wd.last = (i == ev_n - 1);
            due_reports.push_back(wd);
        end
    endtask

    task automatic check_word();
        word_t exp_w;
        if (due_reports.size() == 0) begin
            $error("unexpected report word: known %0b weight %0d last %0b",
                   report_known, report_weight, last);
            errs++;
            return;
        end
        exp_w = due_reports.pop_front();
        if (report_known !== exp_w.known) begin
            $error("report_known mismatch: expected %0b, actual %0b", exp_w.known, report_known);
            errs++;
        end
        if (report_weight !== exp_w.weight) begin
            $error("report_weight mismatch: expected %0d, actual %0d",
                   $signed(exp_w.weight), report_weight);
            errs++;
        end
        if (last !== exp_w.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_w.last, last);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            en          = 1'b0;
            thr         = THRESHOLD_RESET;
            hold        = HOLDOFF_RESET;
            lat_known   = 1'b0;
            lat_weight  = '0;
            seen_sample = 1'b0;
            rep_valid   = 1'b0;
            rep_known   = 1'b0;
            rep_weight  = '0;
            rep_time    = '0;
            held        = 1'b0;
            held_known  = 1'b0;
            held_weight = '0;
            errs        = 0;
            due_reports.delete();
            mismatches <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLED:   en   = cfg_data[0];
                    CFG_THRESHOLD: thr  = cfg_data;
                    CFG_HOLDOFF:   hold = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                coalesce_event(func, sample_known, weight_dg, force_req, now_ms, outbox_accepts);
            if (out_valid && !out_stall)
                check_word();
            mismatches <= errs;
            words_due  <= due_reports.size();
        end
    end

endmodule

// ===== tb/deadband_report_coalescer_tb.sv =====
`timescale 1ns / 100ps

module deadband_report_coalescer_tb;

    import dbrc_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          STALL_HOLD_LEN = 200;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_valid      = 1'b0;
    logic [1:0]                 cfg_index      = '0;
    logic [CFG_W-1:0]           cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic [1:0]                 func           = '0;
    logic                       sample_known   = 1'b0;
    logic signed [WEIGHT_W-1:0] weight_dg      = '0;
    logic                       force_req      = 1'b0;
    logic [TIME_W-1:0]          now_ms         = '0;
    logic                       outbox_accepts = 1'b0;
    logic                       out_stall      = 1'b0;

    logic                       cfg_ready;
    logic                       in_stall;
    logic                       out_valid;
    logic                       report_known;
    logic signed [WEIGHT_W-1:0] report_weight;
    logic                       last;
    int                         mismatches;
    int                         words_due;

    int                         cycles        = 0;
    int                         send_idle_pct = 0;
    int                         stall_pct     = 0;
    int                         hold_reqs     = 0;
    int                         hold_served   = 0;
    int                         hold_left     = 0;
    logic [TIME_W-1:0]          clock_ms      = '0;
    logic signed [WEIGHT_W-1:0] walk_w        = '0;
    logic [CFG_W-1:0]           cur_thr       = THRESHOLD_RESET;
    logic [CFG_W-1:0]           cur_hold      = HOLDOFF_RESET;

    deadband_report_coalescer dut (.*);

    dbrc_report_monitor monitor (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("deadband_report_coalescer verification failed");
            $finish;
        end
    end

    // receiver side, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_served)
        begin
            out_stall   <= 1'b1;
            hold_left   <= STALL_HOLD_LEN;
            hold_served <= hold_reqs;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_event(input logic [1:0] f, input logic k, input logic [WEIGHT_W-1:0] w,
                              input logic frc, input logic [TIME_W-1:0] t, input logic acc);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        sample_known   <= k;
        weight_dg      <= w;
        force_req      <= frc;
        now_ms         <= t;
        outbox_accepts <= acc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_config(input logic e, input logic [CFG_W-1:0] th,
                              input logic [CFG_W-1:0] ho);
        write_reg(CFG_ENABLED, {15'd0, e});
        write_reg(CFG_THRESHOLD, th);
        write_reg(CFG_HOLDOFF, ho);
        cfg_valid <= 1'b0;
        cur_thr  = th;
        cur_hold = ho;
    endtask

    task automatic send_random();
        logic [1:0] f;
        logic       k;
        logic       frc;
        logic       acc;
        int         r;
        int         span;
        r = $urandom_range(99);
        if (r < 84)
            f = FUNC_SAMPLE;
        else if (r < 92)
            f = FUNC_LINK;
        else if (r < 98)
            f = FUNC_OBOX_RESET;
        else
            f = FUNC_UNUSED;
        k    = ($urandom_range(99) < 85);
        frc  = ($urandom_range(99) < 8);
        acc  = ($urandom_range(99) < 85);
        span = 2 * int'(cur_thr) + 4;
        if ($urandom_range(99) < 8)
            walk_w = WEIGHT_W'($urandom);
        else
            walk_w = WEIGHT_W'(walk_w + (int'($urandom_range(0, 2 * span)) - span));
        if ($urandom_range(99) < 5)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 2 * int'(cur_hold) + 2);
        send_event(f, k, walk_w, frc, clock_ms, acc);
    endtask

    task automatic run_phase(input logic e, input logic [CFG_W-1:0] th,
                             input logic [CFG_W-1:0] ho, input int idle, input int stall,
                             input int n);
        drain();
        set_config(e, th, ho);
        send_idle_pct = idle;
        stall_pct    <= stall;
        repeat (n) send_random();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // enabled with no sample ever seen, reset threshold and hold-off
        write_reg(CFG_ENABLED, 16'd1);
        cfg_valid <= 1'b0;
        send_event(FUNC_LINK, 1'b1, 16'd0, 1'b0, 32'd0, 1'b1);
        drain();

        // disabled: sample only recorded
        set_config(1'b0, 16'd10, 16'd1000);
        send_event(FUNC_SAMPLE, 1'b1, 16'd50, 1'b1, 32'd10, 1'b1);
        send_event(FUNC_LINK, 1'b1, 16'd0, 1'b0, 32'd20, 1'b1);
        send_event(FUNC_OBOX_RESET, 1'b0, 16'd0, 1'b0, 32'd30, 1'b1);
        drain();

        set_config(1'b1, 16'd10, 16'd1000);
        send_event(FUNC_SAMPLE, 1'b1, 16'd100, 1'b0, 32'd100, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd105, 1'b0, 32'd110, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd120, 1'b0, 32'd120, 1'b1);
        send_event(FUNC_SAMPLE, 1'b0, -16'sd5, 1'b0, 32'd130, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'h7FFF, 1'b0, 32'd140, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'h8000, 1'b0, 32'd150, 1'b1);
        // window closes exactly at hold-off
        send_event(FUNC_SAMPLE, 1'b1, 16'h8000, 1'b0, 32'd1140, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd0, 1'b0, 32'd1150, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd5, 1'b1, 32'd1160, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd500, 1'b1, 32'd1170, 1'b0);
        send_event(FUNC_LINK, 1'b0, 16'hFFFF, 1'b1, 32'd1180, 1'b1);
        send_event(FUNC_LINK, 1'b1, 16'd0, 1'b0, 32'd1190, 1'b0);
        send_event(FUNC_SAMPLE, 1'b1, 16'd500, 1'b0, 32'd1200, 1'b1);
        send_event(FUNC_OBOX_RESET, 1'b1, 16'd0, 1'b0, 32'd1210, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd501, 1'b0, 32'd1220, 1'b1);
        send_event(FUNC_UNUSED, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // time wrap inside the window
        send_event(FUNC_SAMPLE, 1'b1, 16'd1000, 1'b0, 32'hFFFF_FFF0, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd2000, 1'b0, 32'h0000_0010, 1'b1);
        send_event(FUNC_SAMPLE, 1'b1, 16'd2000, 1'b0, 32'h0000_03E0, 1'b1);
        send_event(FUNC_SAMPLE, 1'b0, 16'd2000, 1'b0, 32'h0000_03F0, 1'b1);
        send_event(FUNC_SAMPLE, 1'b0, 16'd7, 1'b0, 32'h0000_0400, 1'b1);
        clock_ms = 32'h0000_0400;

        run_phase(1'b1, 16'd10, 16'd1000, 0, 0, 60);
        run_phase(1'b1, 16'd0, 16'd0, 50, 0, 60);
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 0, 50, 60);
        run_phase(1'b0, 16'd300, 16'd50, 8, 8, 30);

        // long receiver hold-off while events keep coming
        drain();
        set_config(1'b1, 16'd50, 16'd200);
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_reqs    <= hold_reqs + 1;
        repeat (40) send_random();
        drain();
        send_idle_pct = 8;
        stall_pct    <= 8;
        repeat (40) send_random();

        run_phase(1'b1, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 3000)), 8, 8, 80);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("deadband_report_coalescer verification clean");
        else
            $display("deadband_report_coalescer verification failed");
        $finish;
    end

endmodule
